FILE: rtl/chained_hash_symbol_table_top_defines.svh
// Assertion helpers used by the controller RTL
`ifndef CHAINED_HASH_SYMBOL_TABLE_TOP_DEFINES_SVH
`define CHAINED_HASH_SYMBOL_TABLE_TOP_DEFINES_SVH

// Check a condition at every clock edge out of reset
`define CHST_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("check failed");

// Check that one condition implies another in the next cycle
`define CHST_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("check failed");

`endif

FILE: rtl/chst_pkg.sv
package chst_pkg;

  // Operation codes
  localparam logic [1:0] FUNC_LOOKUP  = 2'd0;
  localparam logic [1:0] FUNC_INSERT  = 2'd1;
  localparam logic [1:0] FUNC_REMOVE  = 2'd2;
  localparam logic [1:0] FUNC_RESOLVE = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_HOPLIM   = 3'd4;

  // Register indexes
  localparam logic REG_ALIAS_CODE = 1'b0;
  localparam logic REG_MAX_HOPS   = 1'b1;

  localparam logic [4:0] HOP_CAP = 5'd16;

  typedef struct packed {
    logic [3:0] alias_code;
    logic [4:0] max_hops;
  } chst_cfg_t;

  typedef struct packed {
    logic [4:0]  hops;
    logic [31:0] value;
    logic [3:0]  etype;
    logic [31:0] key;
    logic [2:0]  status;
  } chst_result_t;

endpackage

FILE: rtl/chst_ram.sv
module chst_ram import chst_pkg::*; #(
  parameter int DW = 8,
  parameter int AW = 4,
  parameter int DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // One write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/chst_ctrl.sv
`include "chained_hash_symbol_table_top_defines.svh"

module chst_ctrl import chst_pkg::*; #(
  parameter int HASH_BITS = 10,
  parameter int POOL_ENTRIES = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  chst_cfg_t    cfg_i,
  input  logic         op_valid_i,
  output logic         op_ready_o,
  input  logic [1:0]   op_func_i,
  input  logic [31:0]  op_key_i,
  input  logic [3:0]   op_type_i,
  input  logic [31:0]  op_value_i,
  output logic         res_valid_o,
  input  logic         res_ready_i,
  output chst_result_t res_o
);

  localparam int BUCKETS = 1 << HASH_BITS;
  localparam int PA = $clog2(POOL_ENTRIES);
  localparam int LW = $clog2(POOL_ENTRIES + 1);
  localparam int CLRN = (BUCKETS > POOL_ENTRIES) ? BUCKETS : POOL_ENTRIES;
  localparam int CW = $clog2(CLRN + 1);
  localparam int PDW = 68 + LW;
  localparam int HDW = PDW + 1;
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_ENTRIES);
  localparam logic [CW-1:0] CLR_LAST = CW'(CLRN - 1);
  localparam logic [CW-1:0] BUCKETS_C = CW'(BUCKETS);
  localparam logic [CW-1:0] POOL_C = CW'(POOL_ENTRIES);
  localparam logic [LW-1:0] POOL_L = LW'(POOL_ENTRIES);

  // Sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HCHK  = 4'd2;
  localparam logic [3:0] S_PCHK  = 4'd3;
  localparam logic [3:0] S_DISP  = 4'd4;
  localparam logic [3:0] S_IFREE = 4'd5;
  localparam logic [3:0] S_ITAIL = 4'd6;
  localparam logic [3:0] S_RHEAD = 4'd7;
  localparam logic [3:0] S_RPREV = 4'd8;
  localparam logic [3:0] S_RREL  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_q, state_d;
  logic [CW-1:0] clr_q, clr_d;
  logic [1:0]  func_q, func_d;
  logic [31:0] okey_q, okey_d, oval_q, oval_d;
  logic [3:0]  otype_q, otype_d;
  logic [31:0] skey_q, skey_d;
  logic [HDW-1:0] hword_q, hword_d;
  logic hit_q, hit_d, athead_q, athead_d, first_q, first_d;
  logic [LW-1:0] idx_q, idx_d, prev_q, prev_d, p_q, p_d, nidx_q, nidx_d;
  logic [LW-1:0] steps_q, steps_d;
  logic [31:0] ek_q, ek_d, ev_q, ev_d;
  logic [3:0]  et_q, et_d;
  logic [LW-1:0] elink_q, elink_d;
  logic [LW-1:0] fhead_q, fhead_d, fcnt_q, fcnt_d;
  chst_result_t res_q, res_d;

  logic [HASH_BITS-1:0] h_raddr, h_waddr;
  logic [PA-1:0] p_raddr, p_waddr;
  logic h_we, p_we;
  logic [HDW-1:0] h_wdata, hrd;
  logic [PDW-1:0] p_wdata, prd;
  logic [4:0] limit;

  chst_ram #(.DW(HDW), .AW(HASH_BITS), .DEPTH(BUCKETS)) u_head (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .raddr_i(h_raddr), .rdata_o(hrd));

  chst_ram #(.DW(PDW), .AW(PA), .DEPTH(POOL_ENTRIES)) u_pool (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(prd));

  assign limit = (cfg_i.max_hops > HOP_CAP) ? HOP_CAP : cfg_i.max_hops;

  // Sequencer: clear pass, chain walk, then the per-operation updates
  always_comb begin
    state_d = state_q; clr_d = clr_q;
    func_d = func_q; okey_d = okey_q; oval_d = oval_q; otype_d = otype_q;
    skey_d = skey_q; hword_d = hword_q; hit_d = hit_q; athead_d = athead_q;
    first_d = first_q; idx_d = idx_q; prev_d = prev_q; p_d = p_q; nidx_d = nidx_q;
    steps_d = steps_q; ek_d = ek_q; ev_d = ev_q; et_d = et_q; elink_d = elink_q;
    fhead_d = fhead_q; fcnt_d = fcnt_q; res_d = res_q;
    h_raddr = skey_q[HASH_BITS-1:0];
    h_waddr = skey_q[HASH_BITS-1:0];
    h_we = 1'b0; h_wdata = hword_q;
    p_raddr = p_q[PA-1:0]; p_waddr = p_q[PA-1:0];
    p_we = 1'b0; p_wdata = prd;
    case (state_q)
      S_CLEAR: begin
        h_waddr = clr_q[HASH_BITS-1:0];
        h_we = (clr_q < BUCKETS_C);
        h_wdata = {1'b0, NULL_LINK, 68'd0};
        p_waddr = clr_q[PA-1:0];
        p_we = (clr_q < POOL_C);
        p_wdata = {LW'(clr_q) + LW'(1), 68'd0};
        clr_d = clr_q + CW'(1);
        if (clr_q == CLR_LAST) state_d = S_IDLE;
      end
      S_IDLE: begin
        h_raddr = op_key_i[HASH_BITS-1:0];
        if (op_valid_i) begin
          func_d = op_func_i; okey_d = op_key_i; otype_d = op_type_i; oval_d = op_value_i;
          skey_d = op_key_i; first_d = 1'b1;
          res_d = '0;
          state_d = S_HCHK;
        end
      end
      S_HCHK: begin
        hword_d = hrd;
        ek_d = hrd[31:0]; et_d = hrd[35:32]; ev_d = hrd[67:36]; elink_d = hrd[PDW-1:68];
        athead_d = 1'b1; hit_d = 1'b0; prev_d = NULL_LINK; steps_d = '0;
        p_d = hrd[PDW-1:68];
        p_raddr = hrd[67+PA:68];
        state_d = S_DISP;
        if (hrd[HDW-1]) begin
          if (hrd[31:0] == skey_q) hit_d = 1'b1;
          else if (hrd[PDW-1:68] < POOL_L) state_d = S_PCHK;
        end
      end
      S_PCHK: begin
        ek_d = prd[31:0]; et_d = prd[35:32]; ev_d = prd[67:36]; elink_d = prd[PDW-1:68];
        athead_d = 1'b0;
        if (prd[31:0] == skey_q) begin
          hit_d = 1'b1; idx_d = p_q;
          state_d = S_DISP;
        end else begin
          prev_d = p_q; p_d = prd[PDW-1:68]; steps_d = steps_q + LW'(1);
          p_raddr = prd[67+PA:68];
          if (prd[PDW-1:68] >= POOL_L || steps_q + LW'(1) == POOL_L) state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_DONE;
        case (func_q)
          FUNC_LOOKUP: begin
            if (hit_q) res_d = '{hops: 5'd0, value: ev_q, etype: et_q, key: ek_q,
                                 status: ST_OK};
            else res_d.status = ST_NOTFOUND;
          end
          FUNC_INSERT: begin
            if (hit_q) begin
              res_d = '{hops: 5'd0, value: ev_q, etype: et_q, key: ek_q, status: ST_DUP};
            end else if (!hword_q[HDW-1]) begin
              h_we = 1'b1;
              h_wdata = {1'b1, NULL_LINK, oval_q, otype_q, okey_q};
              res_d = '{hops: 5'd0, value: oval_q, etype: otype_q, key: okey_q,
                        status: ST_OK};
            end else if (fcnt_q == '0 || fhead_q >= POOL_L) begin
              res_d.status = ST_FULL;
            end else begin
              p_raddr = fhead_q[PA-1:0];
              nidx_d = fhead_q;
              state_d = S_IFREE;
            end
          end
          FUNC_REMOVE: begin
            if (!hit_q) begin
              res_d.status = ST_NOTFOUND;
            end else begin
              res_d = '{hops: 5'd0, value: ev_q, etype: et_q, key: ek_q, status: ST_OK};
              if (athead_q) begin
                if (hword_q[PDW-1:68] < POOL_L) begin
                  p_raddr = hword_q[67+PA:68];
                  state_d = S_RHEAD;
                end else begin
                  h_we = 1'b1;
                  h_wdata = {1'b0, NULL_LINK, hword_q[67:0]};
                end
              end else if (prev_q >= POOL_L) begin
                h_we = 1'b1;
                h_wdata = {hword_q[HDW-1], elink_q, hword_q[67:0]};
                state_d = S_RREL;
              end else begin
                p_raddr = prev_q[PA-1:0];
                state_d = S_RPREV;
              end
            end
          end
          FUNC_RESOLVE: begin
            if (first_q && !hit_q) begin
              res_d.status = ST_NOTFOUND;
            end else if (hit_q) begin
              if (!first_q && res_q.hops >= limit) begin
                res_d.status = ST_HOPLIM;
              end else begin
                res_d.key = ek_q; res_d.etype = et_q; res_d.value = ev_q;
                if (!first_q) res_d.hops = res_q.hops + 5'd1;
                if (et_q == cfg_i.alias_code) begin
                  first_d = 1'b0;
                  skey_d = ev_q;
                  h_raddr = ev_q[HASH_BITS-1:0];
                  state_d = S_HCHK;
                end
              end
            end
          end
          default: ;
        endcase
      end
      S_IFREE: begin
        // Pop the free entry, fill it, then link it at the chain tail
        fhead_d = prd[PDW-1:68];
        fcnt_d = fcnt_q - LW'(1);
        p_we = 1'b1; p_waddr = nidx_q[PA-1:0];
        p_wdata = {NULL_LINK, oval_q, otype_q, okey_q};
        res_d = '{hops: 5'd0, value: oval_q, etype: otype_q, key: okey_q, status: ST_OK};
        p_d = hword_q[PDW-1:68]; steps_d = '0;
        p_raddr = hword_q[67+PA:68];
        if (hword_q[PDW-1:68] >= POOL_L) begin
          h_we = 1'b1;
          h_wdata = {hword_q[HDW-1], nidx_q, hword_q[67:0]};
          state_d = S_DONE;
        end else begin
          state_d = S_ITAIL;
        end
      end
      S_ITAIL: begin
        if (prd[PDW-1:68] < POOL_L && steps_q < POOL_L) begin
          p_d = prd[PDW-1:68]; steps_d = steps_q + LW'(1);
          p_raddr = prd[67+PA:68];
        end else begin
          p_we = 1'b1;
          p_wdata = {nidx_q, prd[67:0]};
          state_d = S_DONE;
        end
      end
      S_RHEAD: begin
        // Pull the successor into the head and free its slot
        h_we = 1'b1;
        h_wdata = {1'b1, prd};
        p_we = 1'b1; p_waddr = hword_q[67+PA:68];
        p_wdata = {fhead_q, prd[67:0]};
        fhead_d = hword_q[PDW-1:68];
        fcnt_d = fcnt_q + LW'(1);
        state_d = S_DONE;
      end
      S_RPREV: begin
        p_we = 1'b1; p_waddr = prev_q[PA-1:0];
        p_wdata = {elink_q, prd[67:0]};
        state_d = S_RREL;
      end
      S_RREL: begin
        p_we = 1'b1; p_waddr = idx_q[PA-1:0];
        p_wdata = {fhead_q, ev_q, et_q, ek_q};
        fhead_d = idx_q;
        fcnt_d = fcnt_q + LW'(1);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      fhead_q <= '0;
      fcnt_q <= POOL_L;
      first_q <= 1'b1;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      fhead_q <= fhead_d;
      fcnt_q <= fcnt_d;
      first_q <= first_d;
    end
  end

  // Operand and walk registers
  always_ff @(posedge clk_i) begin
    func_q <= func_d; okey_q <= okey_d; oval_q <= oval_d; otype_q <= otype_d;
    skey_q <= skey_d; hword_q <= hword_d; hit_q <= hit_d; athead_q <= athead_d;
    idx_q <= idx_d; prev_q <= prev_d; p_q <= p_d; nidx_q <= nidx_d;
    steps_q <= steps_d; ek_q <= ek_d; ev_q <= ev_d; et_q <= et_d; elink_q <= elink_d;
    res_q <= res_d;
  end

  assign op_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o = res_q;

  `CHST_ASSERT(a_fcnt_range, fcnt_q <= POOL_L)
  `CHST_ASSERT(a_empty_list, !(state_q == S_IDLE && fcnt_q == '0) || fhead_q >= POOL_L)
  `CHST_ASSERT(a_hops_range, state_q != S_DONE || res_q.hops <= HOP_CAP)
  `CHST_ASSERT_NEXT(a_res_hold, state_q == S_DONE && !res_ready_i,
                    state_q == S_DONE && $stable(res_q))

endmodule

FILE: rtl/chained_hash_symbol_table_top.sv
// Hash symbol table with chained buckets, one operation per input transaction and
// one result transaction per operation. After reset the block runs a clearing pass
// over every head and pool entry before it takes its first operation. An operation
// then reads the bucket head and walks its chain one pool entry at a time, as the
// head and pool memories, each with one write and one read port, are read once a
// cycle by one sequencer; insert into a chained bucket walks the chain twice, remove
// of a head with a successor adds a write step, remove of a pool entry adds one or
// two write steps, and resolve repeats the lookup once per alias link followed
// (at most 16) and once more when it stops at the hop limit.
// Operations run one at a time; a finished result waits in the output register
// while the next operation starts.
module chained_hash_symbol_table_top import chst_pkg::*; #(
  parameter int HASH_BITS = 10,
  parameter int POOL_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // func[1:0], key[33:2], entry_type[37:34], entry_value[69:38], zero fill
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], found_key[34:3], found_type[38:35], found_value[70:39],
  // hops_taken[75:71], zero fill
  output logic [79:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

  chst_cfg_t cfg_q;
  chst_result_t res;
  logic res_valid, res_ready;
  logic out_valid_q;
  chst_result_t out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alias_code <= 4'd1;
      cfg_q.max_hops <= 5'd10;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ALIAS_CODE: cfg_q.alias_code <= cfg_data_i[3:0];
        REG_MAX_HOPS:   cfg_q.max_hops <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  chst_ctrl #(.HASH_BITS(HASH_BITS), .POOL_ENTRIES(POOL_ENTRIES)) u_ctrl (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .op_valid_i(s_axis_tvalid), .op_ready_o(s_axis_tready),
    .op_func_i(s_axis_tdata[1:0]), .op_key_i(s_axis_tdata[33:2]),
    .op_type_i(s_axis_tdata[37:34]), .op_value_i(s_axis_tdata[69:38]),
    .res_valid_o(res_valid), .res_ready_i(res_ready), .res_o(res));

  // Output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {4'd0, out_q.hops, out_q.value, out_q.etype, out_q.key,
                         out_q.status};

endmodule
